// ===== sv/gtm_pkg.sv =====
`default_nettype none
package gtm_pkg;

  localparam int DEF_MAX_WIDTH = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam logic [6:0] MAP_WIDTH_RESET = 7'd64;
  localparam logic [6:0] MAP_HEIGHT_RESET = 7'd64;

  localparam logic signed [15:0] COST_ONE = 16'sd256;
  localparam logic signed [15:0] COST_MINUS_ONE = -16'sd256;

  typedef enum logic [2:0] {
    CMD_SET_COST  = 3'd0,
    CMD_SET_WALK  = 3'd1,
    CMD_SET_TRANS = 3'd2,
    CMD_QUERY     = 3'd3,
    CMD_NEIGHBORS = 3'd4,
    CMD_CARVE     = 3'd5
  } gtm_cmd_t;

  typedef enum logic [1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_DIAGONALS  = 2'd2
  } gtm_reg_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_BOUNDS = 2'd1,
    ST_UNWALKABLE    = 2'd2
  } gtm_status_t;

  typedef struct packed {
    gtm_status_t        status;
    logic               cell_walk;
    logic               cell_trans;
    logic signed [15:0] cell_cost;
    logic signed [7:0]  neighbour_x;
    logic signed [7:0]  neighbour_y;
    logic               neighbour_valid;
    logic               last;
  } gtm_result_t;

  typedef struct packed {
    logic rd;
    logic wr_cost;
    logic wr_trans;
  } gtm_mem_ctl_t;

  // Clamp a size register to 1..maxv.
  function automatic logic [8:0] eff_limit(input logic [6:0] v, input int maxv);
    logic [8:0] lim;
    lim = 9'(maxv);
    if (v == 7'd0) begin
      return 9'd1;
    end else if ({2'b00, v} > lim) begin
      return lim;
    end
    return {2'b00, v};
  endfunction

  // c is a 9-bit two's complement coordinate.
  function automatic logic in_bounds(input logic [8:0] c, input logic [8:0] lim);
    return !c[8] && ({1'b0, c[7:0]} < lim);
  endfunction

  function automatic logic [8:0] nb_dx(input logic [2:0] slot);
    logic [8:0] d;
    unique case (slot)
      3'd0, 3'd4, 3'd7: d = 9'h1FF;
      3'd1, 3'd5, 3'd6: d = 9'h001;
      default:          d = 9'h000;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] nb_dy(input logic [2:0] slot);
    logic [8:0] d;
    unique case (slot)
      3'd2, 3'd4, 3'd6: d = 9'h1FF;
      3'd3, 3'd5, 3'd7: d = 9'h001;
      default:          d = 9'h000;
    endcase
    return d;
  endfunction

  function automatic gtm_result_t result_status(input gtm_status_t st);
    gtm_result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // An unwalkable cell reports its transparency but no cost.
  function automatic gtm_result_t result_query(input logic walk, input logic trans,
                                               input logic signed [15:0] c);
    gtm_result_t r;
    r = '0;
    r.status = walk ? ST_OK : ST_UNWALKABLE;
    r.cell_walk = walk;
    r.cell_trans = trans;
    r.cell_cost = walk ? c : '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic gtm_result_t result_neighbour(input logic [7:0] x, input logic [7:0] y,
                                                   input logic is_last);
    gtm_result_t r;
    r = '0;
    r.status = ST_OK;
    r.neighbour_x = x;
    r.neighbour_y = y;
    r.neighbour_valid = 1'b1;
    r.last = is_last;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/gtm_req_if.sv =====
`default_nettype none
interface gtm_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic signed [7:0] pos_x;
  logic signed [7:0] pos_y;
  logic signed [7:0] corner_x;
  logic signed [7:0] corner_y;
  logic signed [15:0] cost_value;
  logic              flag;

  modport source (output valid, command, pos_x, pos_y, corner_x, corner_y, cost_value, flag,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, corner_x, corner_y, cost_value, flag,
                output ready);
endinterface
`default_nettype wire

// ===== sv/gtm_rsp_if.sv =====
`default_nettype none
interface gtm_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               cell_walk;
  logic               cell_trans;
  logic signed [15:0] cell_cost;
  logic signed [7:0]  neighbour_x;
  logic signed [7:0]  neighbour_y;
  logic               neighbour_valid;
  logic               last;

  modport source (output valid, status, cell_walk, cell_trans, cell_cost, neighbour_x,
                  neighbour_y, neighbour_valid, last, input ready);
  modport sink (input valid, status, cell_walk, cell_trans, cell_cost, neighbour_x,
                neighbour_y, neighbour_valid, last, output ready);
endinterface
`default_nettype wire

// ===== sv/gtm_cell_store.sv =====
`default_nettype none
module gtm_cell_store
  import gtm_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gtm_mem_ctl_t       ctl,
  input  wire logic [ADDR_W-1:0]  addr,
  input  wire logic signed [15:0] wr_cost,
  input  wire logic               wr_trans,
  output logic signed [15:0]      rd_cost,
  output logic                    rd_trans,
  output logic                    busy
);

  logic signed [15:0] cost_mem [DEPTH];
  logic               trans_mem [DEPTH];
  logic [ADDR_W-1:0]  clr_addr;

  // Sweep every entry back to unwalkable and opaque after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      cost_mem[clr_addr] <= COST_MINUS_ONE;
      trans_mem[clr_addr] <= 1'b0;
    end else begin
      if (ctl.wr_cost) begin
        cost_mem[addr] <= wr_cost;
      end
      if (ctl.wr_trans) begin
        trans_mem[addr] <= wr_trans;
      end
    end
    if (ctl.rd) begin
      rd_cost <= cost_mem[addr];
      rd_trans <= trans_mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/grid_tile_map_store.sv =====
`default_nettype none
// Channel | Dir | Modport | Moves
// req     | in  | sink    | one command request per handshake
// rsp     | out | source  | one result per handshake, last marks the end of a command
// cfg     | in  | write   | map_width, map_height, allow_diagonals
//
// A request is taken in S_IDLE and dispatched from S_DSP in the next cycle. Set
// cost and set transparency write the store from S_DSP; query and set walkable do
// one store read first. Neighbours reads the store for each in-bounds probe (4 or 8
// probes) through the single store port. Carve walks its cells column by column.
// After reset all MAX_WIDTH*MAX_HEIGHT store entries are swept, with req.ready low.
// A stalled rsp holds the block only when a further result is due.
module grid_tile_map_store
  import gtm_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  gtm_req_if.sink         req,
  gtm_rsp_if.source       rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_DSP, S_SETW, S_QRY, S_NBP, S_NBC, S_NBE, S_CARVE, S_EMIT
  } state_t;

  state_t             state;
  logic [6:0]         map_width;
  logic [6:0]         map_height;
  logic               allow_diag;
  logic [2:0]         cmd;
  logic signed [7:0]  px;
  logic signed [7:0]  py;
  logic signed [7:0]  cx;
  logic signed [7:0]  cy;
  logic signed [15:0] cost;
  logic               flag;
  logic signed [7:0]  cur_x;
  logic signed [7:0]  cur_y;
  logic [2:0]         slot;
  logic               pend_valid;
  logic [7:0]         pend_x;
  logic [7:0]         pend_y;
  gtm_result_t        res;
  gtm_result_t        rsp_q;
  logic               rsp_valid;
  logic               rsp_load;

  gtm_mem_ctl_t       ctl;
  logic [ADDR_W-1:0]  addr;
  logic [7:0]         addr_x;
  logic [7:0]         addr_y;
  logic signed [15:0] wr_cost;
  logic               wr_trans;
  logic signed [15:0] rd_cost;
  logic               rd_trans;
  logic               store_busy;

  logic [8:0]         eff_w;
  logic [8:0]         eff_h;
  logic [8:0]         probe_x;
  logic [8:0]         probe_y;
  logic               home_in;
  logic               probe_in;
  logic               cur_in;
  logic               carve_empty;
  logic               last_probe;
  logic               out_free;
  logic               walkable;

  gtm_cell_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .addr    (addr),
    .wr_cost (wr_cost),
    .wr_trans(wr_trans),
    .rd_cost (rd_cost),
    .rd_trans(rd_trans),
    .busy    (store_busy)
  );

  assign eff_w = eff_limit(map_width, MAX_WIDTH);
  assign eff_h = eff_limit(map_height, MAX_HEIGHT);
  assign probe_x = {px[7], px} + nb_dx(slot);
  assign probe_y = {py[7], py} + nb_dy(slot);
  assign home_in = in_bounds({px[7], px}, eff_w) && in_bounds({py[7], py}, eff_h);
  assign probe_in = in_bounds(probe_x, eff_w) && in_bounds(probe_y, eff_h);
  assign cur_in = in_bounds({cur_x[7], cur_x}, eff_w) && in_bounds({cur_y[7], cur_y}, eff_h);
  assign carve_empty = (cx < px) || (cy < py);
  assign last_probe = (slot == (allow_diag ? 3'd7 : 3'd3));
  assign out_free = !rsp_valid || rsp.ready;
  assign walkable = !rd_cost[15];

  // Load the output register: final result, or a held-back neighbour pushed out
  assign rsp_load = out_free && ((state == S_EMIT) || (state == S_NBE) ||
                                 ((state == S_NBC) && walkable && pend_valid));

  assign req.ready = (state == S_IDLE) && !store_busy;

  always_comb begin
    unique case (state)
      S_NBP, S_NBC: begin
        addr_x = probe_x[7:0];
        addr_y = probe_y[7:0];
      end
      S_CARVE: begin
        addr_x = cur_x;
        addr_y = cur_y;
      end
      default: begin
        addr_x = px;
        addr_y = py;
      end
    endcase
    addr = ADDR_W'(int'(addr_y) * MAX_WIDTH + int'(addr_x));
  end

  always_comb begin
    ctl = '0;
    wr_cost = cost;
    wr_trans = flag;
    unique case (state)
      S_DSP: begin
        if (home_in) begin
          ctl.wr_cost = (cmd == CMD_SET_COST);
          ctl.wr_trans = (cmd == CMD_SET_TRANS);
          ctl.rd = (cmd == CMD_SET_WALK) || (cmd == CMD_QUERY);
        end
      end
      S_SETW: begin
        // A walkable cell asked to become walkable keeps its cost.
        ctl.wr_cost = !(flag && walkable);
        wr_cost = flag ? COST_ONE : COST_MINUS_ONE;
      end
      S_NBP: ctl.rd = probe_in;
      S_CARVE: begin
        ctl.wr_cost = cur_in;
        ctl.wr_trans = cur_in;
        wr_trans = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      map_width <= MAP_WIDTH_RESET;
      map_height <= MAP_HEIGHT_RESET;
      allow_diag <= 1'b0;
      pend_valid <= 1'b0;
      slot <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MAP_WIDTH:  map_width <= cfg_data;
          REG_MAP_HEIGHT: map_height <= cfg_data;
          REG_DIAGONALS:  allow_diag <= cfg_data[0];
          default: ;
        endcase
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cmd <= req.command;
            px <= req.pos_x;
            py <= req.pos_y;
            cx <= req.corner_x;
            cy <= req.corner_y;
            cost <= req.cost_value;
            flag <= req.flag;
            state <= S_DSP;
          end
        end
        S_DSP: begin
          unique case (cmd)
            CMD_SET_COST, CMD_SET_TRANS: begin
              res <= result_status(home_in ? ST_OK : ST_OUT_OF_BOUNDS);
              state <= S_EMIT;
            end
            CMD_SET_WALK: begin
              res <= result_status(ST_OUT_OF_BOUNDS);
              state <= home_in ? S_SETW : S_EMIT;
            end
            CMD_QUERY: begin
              res <= result_status(ST_OUT_OF_BOUNDS);
              state <= home_in ? S_QRY : S_EMIT;
            end
            CMD_NEIGHBORS: begin
              res <= result_status(ST_OUT_OF_BOUNDS);
              slot <= '0;
              pend_valid <= 1'b0;
              state <= home_in ? S_NBP : S_EMIT;
            end
            CMD_CARVE: begin
              res <= result_status(ST_OK);
              cur_x <= px;
              cur_y <= py;
              state <= carve_empty ? S_EMIT : S_CARVE;
            end
            default: begin
              res <= result_status(ST_OK);
              state <= S_EMIT;
            end
          endcase
        end
        S_SETW: begin
          res <= result_status(ST_OK);
          state <= S_EMIT;
        end
        S_QRY: begin
          res <= result_query(walkable, rd_trans, rd_cost);
          state <= S_EMIT;
        end
        S_NBP: begin
          if (probe_in) begin
            state <= S_NBC;
          end else if (last_probe) begin
            state <= S_NBE;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_NBC: begin
          // Hold one neighbour back so that the final one can carry last.
          if (!(walkable && pend_valid && !out_free)) begin
            if (walkable) begin
              if (pend_valid) begin
                rsp_q <= result_neighbour(pend_x, pend_y, 1'b0);
              end
              pend_x <= probe_x[7:0];
              pend_y <= probe_y[7:0];
              pend_valid <= 1'b1;
            end
            if (last_probe) begin
              state <= S_NBE;
            end else begin
              slot <= slot + 1'b1;
              state <= S_NBP;
            end
          end
        end
        S_NBE: begin
          if (out_free) begin
            rsp_q <= pend_valid ? result_neighbour(pend_x, pend_y, 1'b1)
                                : result_status(ST_OK);
            state <= S_IDLE;
          end
        end
        S_CARVE: begin
          if (!cur_in) begin
            res <= result_status(ST_OUT_OF_BOUNDS);
            state <= S_EMIT;
          end else if (cur_y == cy) begin
            if (cur_x == cx) begin
              state <= S_EMIT;
            end else begin
              cur_x <= cur_x + 8'sd1;
              cur_y <= py;
            end
          end else begin
            cur_y <= cur_y + 8'sd1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_q <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.status = rsp_q.status;
  assign rsp.cell_walk = rsp_q.cell_walk;
  assign rsp.cell_trans = rsp_q.cell_trans;
  assign rsp.cell_cost = rsp_q.cell_cost;
  assign rsp.neighbour_x = rsp_q.neighbour_x;
  assign rsp.neighbour_y = rsp_q.neighbour_y;
  assign rsp.neighbour_valid = rsp_q.neighbour_valid;
  assign rsp.last = rsp_q.last;

`ifndef SYNTHESIS
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> !req.ready)
    else $error("request taken during store clear");

  a_read_consumed: assert property (@(posedge clk) disable iff (rst)
    ctl.rd |=> (state == S_SETW || state == S_QRY || state == S_NBC))
    else $error("store read issued with no state to consume it");

  a_req_dispatched: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_DSP)
    else $error("accepted request not dispatched");

  a_neighbour_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.neighbour_valid |-> rsp.status == ST_OK && !rsp.cell_walk)
    else $error("neighbour result with bad status");
`endif

endmodule
`default_nettype wire

// ===== tb/grid_tile_map_store_tb.sv =====
module grid_tile_map_store_tb;
  import gtm_pkg::*;

  localparam int GRID_COLS = DEF_MAX_WIDTH;
  localparam int GRID_ROWS = DEF_MAX_HEIGHT;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  // Codes the block ignores
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [7:0]  pos_x;
    logic signed [7:0]  pos_y;
    logic signed [7:0]  corner_x;
    logic signed [7:0]  corner_y;
    logic signed [15:0] cost_value;
    logic               flag;
  } tile_req_t;

  localparam int REQ_BITS = $bits(tile_req_t);

  logic       clk;
  logic       rst;
  logic       cfg_write;
  gtm_reg_t   cfg_index;
  logic [6:0] cfg_data;

  gtm_req_if req_bus ();
  gtm_rsp_if rsp_bus ();

  grid_tile_map_store DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  // Shadow copy of the tile store and the registers
  logic signed [15:0] cost_mem [0:GRID_COLS*GRID_ROWS-1];
  logic               trans_mem [0:GRID_COLS*GRID_ROWS-1];
  logic [6:0]         width_reg;
  logic [6:0]         height_reg;
  logic               diag_on;

  gtm_result_t due_results [$];

  int req_idle_pct = 0;
  int rsp_idle_pct = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int neighbour_hits = 0;
  int carve_cells = 0;
  int map_settings = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_size(input logic [6:0] v, input int maxv);
    if (v == 7'd0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int eff_cols();
    return clamp_size(width_reg, GRID_COLS);
  endfunction

  function automatic int eff_rows();
    return clamp_size(height_reg, GRID_ROWS);
  endfunction

  function automatic bit cell_outside(input int x, input int y);
    return x < 0 || y < 0 || x >= eff_cols() || y >= eff_rows();
  endfunction

  function automatic int cell_index(input int x, input int y);
    return y * GRID_COLS + x;
  endfunction

  function automatic bit cell_walkable(input int x, input int y);
    if (cell_outside(x, y)) return 1'b0;
    return cost_mem[cell_index(x, y)] >= 0;
  endfunction

  // Probe order: left, right, up, down, then the four diagonals
  function automatic int probe_dx(input int i);
    case (i)
      0, 4, 7: return -1;
      1, 5, 6: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int probe_dy(input int i);
    case (i)
      2, 4, 6: return -1;
      3, 5, 7: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void queue_status_result(input gtm_status_t st);
    gtm_result_t res;
    res = '0;
    res.status = st;
    res.last = 1'b1;
    due_results = {due_results, res};
  endfunction

  function automatic string fmt_result(input gtm_result_t r);
    return $sformatf("st=%0d walk=%0d trans=%0d cost=%0d nb=(%0d,%0d) nv=%0d last=%0d",
                     r.status, r.cell_walk, r.cell_trans, r.cell_cost,
                     r.neighbour_x, r.neighbour_y, r.neighbour_valid, r.last);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // Update the shadow store and queue the results one command produces
  function automatic void apply_tile_command(input tile_req_t r);
    int px, py, cx, cy, nx, ny, n, probes, idx;
    int hit_x [8];
    int hit_y [8];
    bit stop;
    gtm_result_t res;
    px = $signed(r.pos_x);
    py = $signed(r.pos_y);
    cx = $signed(r.corner_x);
    cy = $signed(r.corner_y);
    case (r.command)
      CMD_SET_COST, CMD_SET_WALK, CMD_SET_TRANS: begin
        if (cell_outside(px, py)) begin
          queue_status_result(ST_OUT_OF_BOUNDS);
        end else begin
          idx = cell_index(px, py);
          if (r.command == CMD_SET_COST) begin
            cost_mem[idx] = r.cost_value;
          end else if (r.command == CMD_SET_WALK) begin
            // a walkable cell keeps its cost when made walkable again
            if (!(r.flag && cell_walkable(px, py)))
              cost_mem[idx] = r.flag ? COST_ONE : COST_MINUS_ONE;
          end else begin
            trans_mem[idx] = r.flag;
          end
          queue_status_result(ST_OK);
        end
      end
      CMD_QUERY: begin
        if (cell_outside(px, py)) begin
          queue_status_result(ST_OUT_OF_BOUNDS);
        end else begin
          idx = cell_index(px, py);
          res = '0;
          res.last = 1'b1;
          res.cell_trans = trans_mem[idx];
          if (cost_mem[idx] < 0) begin
            res.status = ST_UNWALKABLE;
          end else begin
            res.status = ST_OK;
            res.cell_walk = 1'b1;
            res.cell_cost = cost_mem[idx];
          end
          due_results = {due_results, res};
        end
      end
      CMD_NEIGHBORS: begin
        if (cell_outside(px, py)) begin
          queue_status_result(ST_OUT_OF_BOUNDS);
        end else begin
          n = 0;
          probes = diag_on ? 8 : 4;
          for (int i = 0; i < probes; i++) begin
            nx = px + probe_dx(i);
            ny = py + probe_dy(i);
            if (cell_walkable(nx, ny)) begin
              hit_x[n] = nx;
              hit_y[n] = ny;
              n++;
            end
          end
          if (n == 0) begin
            queue_status_result(ST_OK);
          end else begin
            for (int k = 0; k < n; k++) begin
              res = '0;
              res.status = ST_OK;
              res.neighbour_x = 8'(hit_x[k]);
              res.neighbour_y = 8'(hit_y[k]);
              res.neighbour_valid = 1'b1;
              res.last = (k == n - 1);
              due_results = {due_results, res};
            end
            neighbour_hits += n;
          end
        end
      end
      CMD_CARVE: begin
        stop = 1'b0;
        // x-major walk; stop at the first cell off the map
        for (int x = px; x <= cx && !stop; x++) begin
          for (int y = py; y <= cy && !stop; y++) begin
            if (cell_outside(x, y)) begin
              stop = 1'b1;
            end else begin
              cost_mem[cell_index(x, y)] = r.cost_value;
              trans_mem[cell_index(x, y)] = 1'b1;
              carve_cells++;
            end
          end
        end
        queue_status_result(stop ? ST_OUT_OF_BOUNDS : ST_OK);
      end
      default: queue_status_result(ST_OK);
    endcase
  endfunction

  function automatic tile_req_t make_req(input logic [2:0] command, input logic [7:0] px,
                                         input logic [7:0] py, input logic [7:0] cx,
                                         input logic [7:0] cy, input logic [15:0] cost,
                                         input logic flag);
    tile_req_t r;
    r.command = command;
    r.pos_x = px;
    r.pos_y = py;
    r.corner_x = cx;
    r.corner_y = cy;
    r.cost_value = cost;
    r.flag = flag;
    return r;
  endfunction

  // Called right after a rising edge; returns at the edge that takes the request
  task automatic issue_request(input tile_req_t r);
    while ($urandom_range(99) < req_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.command <= r.command;
    req_bus.pos_x <= r.pos_x;
    req_bus.pos_y <= r.pos_y;
    req_bus.corner_x <= r.corner_x;
    req_bus.corner_y <= r.corner_y;
    req_bus.cost_value <= r.cost_value;
    req_bus.flag <= r.flag;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    apply_tile_command(r);
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    req_bus.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input gtm_reg_t idx, input logic [6:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MAP_WIDTH:  width_reg = data;
      REG_MAP_HEIGHT: height_reg = data;
      default:        diag_on = data[0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_map(input logic [6:0] w, input logic [6:0] h, input logic [6:0] diag);
    wait_for_drain();
    write_register(REG_MAP_WIDTH, w);
    write_register(REG_MAP_HEIGHT, h);
    write_register(REG_DIAGONALS, diag);
    map_settings++;
  endtask

  function automatic logic [7:0] pick_coord(input int lim);
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(lim + 1) - 1);
  endfunction

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom);
      4:       return 16'h0000;
      default: return 16'($urandom_range(2047));
    endcase
  endfunction

  task automatic test_reset_contents();
    issue_request(make_req(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    issue_request(make_req(CMD_QUERY, 63, 63, 0, 0, 0, 0));
    issue_request(make_req(CMD_NEIGHBORS, 20, 20, 0, 0, 0, 0));
  endtask

  task automatic test_cell_commands();
    issue_request(make_req(CMD_SET_COST, 0, 0, 8'h80, 8'h7F, 16'h7FFF, 1));
    issue_request(make_req(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    issue_request(make_req(CMD_SET_COST, 1, 0, 0, 0, 16'h8000, 0));
    issue_request(make_req(CMD_QUERY, 1, 0, 0, 0, 0, 0));
    issue_request(make_req(CMD_SET_WALK, 1, 0, 0, 0, 0, 1));
    issue_request(make_req(CMD_SET_WALK, 0, 0, 0, 0, 0, 1));
    issue_request(make_req(CMD_SET_TRANS, 0, 0, 0, 0, 0, 1));
    issue_request(make_req(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    issue_request(make_req(CMD_SET_WALK, 1, 0, 0, 0, 0, 0));
    issue_request(make_req(CMD_SET_COST, -128, 127, 0, 0, 16'h0100, 0));
    issue_request(make_req(CMD_QUERY, 127, -1, 0, 0, 0, 0));
    issue_request(make_req(CMD_NEIGHBORS, -1, 5, 0, 0, 0, 0));
    issue_request(make_req(CMD_SPARE_6, 3, 3, 0, 0, 16'h0100, 1));
    issue_request(make_req(CMD_SPARE_7, 3, 3, 0, 0, 16'h0100, 1));
  endtask

  task automatic test_carve_cases();
    issue_request(make_req(CMD_CARVE, 3, 3, 5, 4, 16'h0080, 0));
    issue_request(make_req(CMD_NEIGHBORS, 4, 2, 0, 0, 0, 0));
    // corner left of the start: nothing written
    issue_request(make_req(CMD_CARVE, 5, 5, 4, 9, 16'h0080, 0));
    // runs off the right edge after four cells
    issue_request(make_req(CMD_CARVE, 62, 10, 65, 11, 16'h0140, 0));
    issue_request(make_req(CMD_QUERY, 63, 11, 0, 0, 0, 0));
  endtask

  task automatic test_map_size_limits();
    set_map(7'd1, 7'd0, 7'h7F);
    issue_request(make_req(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    issue_request(make_req(CMD_NEIGHBORS, 0, 0, 0, 0, 0, 0));
    set_map(7'd127, 7'd127, 7'h01);
    issue_request(make_req(CMD_CARVE, 0, 0, 63, 63, 16'h0100, 0));
    issue_request(make_req(CMD_NEIGHBORS, 10, 10, 0, 0, 0, 0));
    issue_request(make_req(CMD_NEIGHBORS, 63, 63, 0, 0, 0, 0));
  endtask

  task automatic run_random_mix(input int count);
    tile_req_t r;
    int w, h, pick;
    for (int k = 0; k < count; k++) begin
      w = eff_cols();
      h = eff_rows();
      pick = $urandom_range(99);
      r = make_req(CMD_QUERY, pick_coord(w), pick_coord(h), 8'($urandom_range(255)),
                   8'($urandom_range(255)), pick_cost(), 1'($urandom_range(1)));
      if (pick < 15) begin
        r.command = CMD_CARVE;
        // mostly small rectangles so carving stays cheap
        if ($urandom_range(4) != 0) begin
          r.corner_x = r.pos_x + 8'($urandom_range(3));
          r.corner_y = r.pos_y + 8'($urandom_range(3));
        end
        if ($urandom_range(3) != 0) r.cost_value = 16'($urandom_range(1023));
      end else if (pick < 30) begin
        r.command = CMD_SET_COST;
      end else if (pick < 45) begin
        r.command = CMD_SET_WALK;
      end else if (pick < 55) begin
        r.command = CMD_SET_TRANS;
      end else if (pick < 75) begin
        r.command = CMD_QUERY;
      end else if (pick < 96) begin
        r.command = CMD_NEIGHBORS;
      end else if (pick < 98) begin
        r.command = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
      end else begin
        r = tile_req_t'(REQ_BITS'({$urandom, $urandom}));
        // keep stray carves from sweeping the whole map
        if (r.command == CMD_CARVE) r.corner_x = r.pos_x;
      end
      issue_request(r);
    end
  endtask

  task automatic test_random_small_map();
    set_map(7'd8, 7'd8, 7'h7F);
    run_random_mix(150);
  endtask

  task automatic test_random_full_map();
    set_map(7'd64, 7'd64, 7'h7E);
    req_idle_pct = 47;
    rsp_idle_pct = 35;
    run_random_mix(150);
  endtask

  task automatic test_random_odd_map();
    set_map(7'd13, 7'd5, 7'h01);
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    run_random_mix(130);
  endtask

  // Receiver: randomize ready and score every accepted result
  always @(posedge clk) begin
    gtm_result_t got, want;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.status = gtm_status_t'(rsp_bus.status);
        got.cell_walk = rsp_bus.cell_walk;
        got.cell_trans = rsp_bus.cell_trans;
        got.cell_cost = rsp_bus.cell_cost;
        got.neighbour_x = rsp_bus.neighbour_x;
        got.neighbour_y = rsp_bus.neighbour_y;
        got.neighbour_valid = rsp_bus.neighbour_valid;
        got.last = rsp_bus.last;
        results_seen++;
        if (due_results.size() == 0) begin
          note_failure({"result with no request pending: ", fmt_result(got)});
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.cell_walk !== want.cell_walk ||
              got.cell_trans !== want.cell_trans ||
              got.cell_cost !== want.cell_cost || got.neighbour_x !== want.neighbour_x ||
              got.neighbour_y !== want.neighbour_y ||
              got.neighbour_valid !== want.neighbour_valid || got.last !== want.last)
            note_failure($sformatf("result %0d\n  want %s\n  got  %s", results_seen,
                                   fmt_result(want), fmt_result(got)));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
               due_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < GRID_COLS * GRID_ROWS; i++) begin
      cost_mem[i] = COST_MINUS_ONE;
      trans_mem[i] = 1'b0;
    end
    width_reg = MAP_WIDTH_RESET;
    height_reg = MAP_HEIGHT_RESET;
    diag_on = 1'b0;

    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data <= '0;
    req_bus.valid <= 1'b0;
    req_bus.command <= CMD_SET_COST;
    req_bus.pos_x <= '0;
    req_bus.pos_y <= '0;
    req_bus.corner_x <= '0;
    req_bus.corner_y <= '0;
    req_bus.cost_value <= '0;
    req_bus.flag <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    req_idle_pct = 35;
    rsp_idle_pct = 47;
    test_reset_contents();
    test_cell_commands();
    test_carve_cases();
    test_map_size_limits();
    test_random_small_map();
    test_random_full_map();
    test_random_odd_map();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", due_results.size()));

    $display("Ran %0d requests over %0d map settings, checked %0d results.",
             requests_sent, map_settings, results_seen);
    $display("Neighbours listed: %0d, cells carved: %0d, mismatches: %0d.",
             neighbour_hits, carve_cells, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
